/* sv/positional_list_store_core_assert.svh */
// Assertion macros used by the checker file of the list store.
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/plsc_pkg.sv */
// Package with the command, status and cell mode codes and the transfer structs of the list store.
`default_nettype none
package plsc_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_SHOW      = 3'd1,
    CMD_INS_FRONT = 3'd2,
    CMD_INS_BACK  = 3'd3,
    CMD_INS_AT    = 3'd4,
    CMD_RM_FRONT  = 3'd5,
    CMD_RM_BACK   = 3'd6,
    CMD_RM_AT     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_ROTATE = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [5:0]         position;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic [4:0]         slot;
    logic [5:0]         count_now;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

/* sv/plsc_cell.sv */
// One storage cell of the list chain; it holds, loads, takes a neighbor's value or takes the head value.
`default_nettype none
module plsc_cell #(
  parameter int WIDTH = 32,
  parameter int IW    = 5,
  parameter int INDEX = 0
) (
  input  wire logic                 clk,
  input  wire plsc_pkg::cell_mode_t mode,
  input  wire logic [IW-1:0]        sel_idx,
  input  wire logic [WIDTH-1:0]     new_val,
  input  wire logic [WIDTH-1:0]     head,
  input  wire logic [WIDTH-1:0]     left,
  input  wire logic [WIDTH-1:0]     right,
  output logic [WIDTH-1:0]          q
);
  import plsc_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    case (mode)
      MODE_INSERT: begin
        // The cell at the insert point loads; cells above it move up by one.
        if (MY_IDX == sel_idx) begin
          q_next = new_val;
        end else if (MY_IDX > sel_idx) begin
          q_next = left;
        end
      end
      MODE_REMOVE: begin
        if (MY_IDX >= sel_idx) begin
          q_next = right;
        end
      end
      MODE_ROTATE: begin
        // The occupied part turns by one: the front value wraps to the back.
        if (MY_IDX < sel_idx) begin
          q_next = right;
        end else begin
          q_next = head;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

/* sv/positional_list_store_core.sv */
// Top level of the list store: control, count register and the chain of storage cells.
// Usage:
//   Raise start with a command item on item; it is taken at a rising edge where busy is
//   low. Every result appears on result for exactly one cycle with result_valid high;
//   the receiver cannot stall, so it must take each result as it comes.
// Command flow:
//   Clear, insert and remove commands act at the edge that takes them; insert and
//   removal at the front or at a position shift the chain there. The status result
//   shows in the next cycle. A new command may be given in every cycle while busy is
//   low. Show with N stored elements keeps busy high while its N results are formed;
//   the chain turns by one cell per cycle and the front cell feeds one result per
//   cycle, the first one through the state register, then the result register. Show
//   on an empty list behaves like an edit. The rotation through the chain sets the show
//   time; after N turns the order is restored.
// Reset:
//   rst empties the list and drops busy and result_valid. The cell contents are not
//   cleared; only cells below the count are ever shown.
`default_nettype none
module positional_list_store_core #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire plsc_pkg::item_t  item,
  output logic                  busy,
  output logic                  result_valid,
  output plsc_pkg::result_t     result
);
  import plsc_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SHOW = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [IW-1:0]          show_cnt, show_cnt_next;
  cell_mode_t             mode;
  logic [IW-1:0]          sel_idx;
  logic [VALUE_WIDTH-1:0] new_val;
  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic                   result_valid_next;
  result_t                result_next;
  logic                   accept;
  logic                   pos_ok;
  logic                   full;
  logic                   empty;

  assign busy    = (state == S_SHOW);
  assign accept  = start && (state == S_IDLE);
  assign new_val = VALUE_WIDTH'(item.value);
  assign pos_ok  = (item.position != 6'd0) && (PW'(item.position) <= PW'(count));
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  always_comb begin
    state_next                  = state;
    count_next                  = count;
    show_cnt_next               = show_cnt;
    mode                        = MODE_HOLD;
    sel_idx                     = '0;
    result_valid_next           = 1'b0;
    result_next.status          = STAT_OK;
    result_next.element         = '0;
    result_next.slot            = '0;
    result_next.count_now       = '0;
    result_next.last            = 1'b1;

    if (state == S_SHOW) begin
      mode                = MODE_ROTATE;
      sel_idx             = IW'(count - CW'(1));
      result_valid_next   = 1'b1;
      result_next.element = 32'(cell_q[0]);
      result_next.slot    = 5'(show_cnt);
      result_next.last    = (CW'(show_cnt) + CW'(1) == count);
      if (result_next.last) begin
        state_next = S_IDLE;
      end else begin
        show_cnt_next = show_cnt + IW'(1);
      end
    end else if (accept) begin
      result_valid_next = 1'b1;
      case (cmd_t'(item.command))
        CMD_CLEAR: begin
          count_next = '0;
        end
        CMD_SHOW: begin
          if (empty) begin
            result_next.status = STAT_EMPTY;
          end else begin
            // Results come from the rotation that starts next cycle.
            result_valid_next = 1'b0;
            state_next        = S_SHOW;
            show_cnt_next     = '0;
          end
        end
        CMD_INS_FRONT: begin
          if (full) begin
            result_next.status = STAT_FULL;
          end else begin
            mode       = MODE_INSERT;
            sel_idx    = '0;
            count_next = count + CW'(1);
          end
        end
        CMD_INS_BACK: begin
          if (full) begin
            result_next.status = STAT_FULL;
          end else begin
            mode       = MODE_INSERT;
            sel_idx    = IW'(count);
            count_next = count + CW'(1);
          end
        end
        CMD_INS_AT: begin
          if (!pos_ok) begin
            result_next.status = STAT_BADPOS;
          end else if (full) begin
            result_next.status = STAT_FULL;
          end else begin
            mode       = MODE_INSERT;
            sel_idx    = IW'(item.position - 6'd1);
            count_next = count + CW'(1);
          end
        end
        CMD_RM_FRONT: begin
          if (empty) begin
            result_next.status = STAT_EMPTY;
          end else begin
            mode       = MODE_REMOVE;
            sel_idx    = '0;
            count_next = count - CW'(1);
          end
        end
        CMD_RM_BACK: begin
          if (empty) begin
            result_next.status = STAT_EMPTY;
          end else begin
            count_next = count - CW'(1);
          end
        end
        CMD_RM_AT: begin
          if (!pos_ok) begin
            result_next.status = STAT_BADPOS;
          end else begin
            mode       = MODE_REMOVE;
            sel_idx    = IW'(item.position - 6'd1);
            count_next = count - CW'(1);
          end
        end
        default: begin
          result_next.status = STAT_OK;
        end
      endcase
    end
    result_next.count_now = 6'(count_next);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    plsc_cell #(
      .WIDTH (VALUE_WIDTH),
      .IW    (IW),
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .mode    (mode),
      .sel_idx (sel_idx),
      .new_val (new_val),
      .head    (cell_q[0]),
      .left    (cell_q[(g == 0) ? 0 : g - 1]),
      .right   (cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      show_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      show_cnt     <= show_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

/* sv/plsc_checker.sv */
// Port-level checker for the list store and the bind that attaches it.
`default_nettype none
`include "positional_list_store_core_assert.svh"
module plsc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire plsc_pkg::item_t   item,
  input wire logic              result_valid,
  input wire plsc_pkg::result_t result
);
  import plsc_pkg::*;

  // Every command except show answers with one final result in the next cycle.
  `PLSC_ASSERT_NEXT(a_edit_answers, start && !busy && item.command != CMD_SHOW, result_valid && result.last)
  // A show run delivers its results in consecutive cycles.
  `PLSC_ASSERT_NEXT(a_show_unbroken, result_valid && !result.last, result_valid)
  // Error results carry no element and end the command.
  `PLSC_ASSERT_SAME(a_error_clean, result_valid && result.status != STAT_OK, result.element == 32'sd0 && result.last)
  // Busy only covers a show that still has results to deliver.
  `PLSC_ASSERT_NEXT(a_busy_yields, busy, result_valid)

endmodule

bind positional_list_store_core plsc_checker u_plsc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
`default_nettype wire
